// ===== rtl/cnb_pkg.sv =====
package cnb_pkg;

  localparam int NUM_ATTRS_D   = 16;
  localparam int NUM_VALUES_D  = 16;
  localparam int NUM_CLASSES_D = 4;
  localparam int COUNT_WIDTH_D = 16;
  localparam int SCORE_W       = 32;
  localparam int TOTAL_W       = 16;
  localparam int CMD_W         = 2;
  localparam int POS_W         = 4;
  localparam int VAL_W         = 4;
  localparam int LBL_W         = 2;
  localparam int CIU_W         = 3;
  localparam int DIV_W         = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_TRAIN = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_TR_RD,
    S_TR_WR,
    S_TE_RD,
    S_TE_PRI,
    S_TE_PRIW,
    S_TE_MUL,
    S_TE_DIV,
    S_TE_DIVW,
    S_TE_CMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic tr_write;
    logic tr_last;
    logic te_start;
    logic pri_start;
    logic pri_store;
    logic mul;
    logic div_start;
    logic div_store;
    logic next_class;
    logic cmp;
    logic result;
    logic wipe_small;
  } cnb_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic last_class;
    logic cmd_clear;
    logic cmd_train;
    logic cmd_test;
    logic lbl_ok;
    logic pos_zero;
    logic row_last;
  } cnb_sts_t;

endpackage

// ===== rtl/cnb_ram.sv =====
module cnb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cnb_div.sv =====
module cnb_div
  import cnb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      dvs_r;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [32:0]      sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == 7'd1);
    sh       = {rem_r, q_r[DIV_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(sh - {1'b0, dvs_r});
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[31:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ===== rtl/cnb_ctrl.sv =====
module cnb_ctrl
  import cnb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  input  cnb_sts_t sts,
  output cnb_cmd_t cmd,
  output logic     in_rdy
);
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (sts.cmd_clear)      state_nxt = S_CLR;
          else if (sts.cmd_train) state_nxt = sts.lbl_ok ? S_TR_RD : S_IDLE;
          else if (sts.cmd_test)  state_nxt = S_TE_RD;
        end
      end
      S_TR_RD:   state_nxt = S_TR_WR;
      S_TR_WR:   state_nxt = S_IDLE;
      S_TE_RD:   state_nxt = sts.pos_zero ? S_TE_PRI : S_TE_MUL;
      S_TE_PRI:  state_nxt = S_TE_PRIW;
      S_TE_PRIW: if (sts.div_done) state_nxt = S_TE_MUL;
      S_TE_MUL:  state_nxt = S_TE_DIV;
      S_TE_DIV:  state_nxt = S_TE_DIVW;
      S_TE_DIVW: begin
        if (sts.div_done) begin
          if (!sts.last_class)     state_nxt = S_TE_RD;
          else if (sts.row_last)   state_nxt = S_TE_CMP;
          else                     state_nxt = S_IDLE;
        end
      end
      S_TE_CMP:  state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    in_rdy = 1'b0;
    unique case (state_r)
      S_CLR:     cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_rdy         = 1'b1;
        cmd.load       = in_fire;
        cmd.wipe_small = in_fire && sts.cmd_clear;
        cmd.te_start   = in_fire && sts.cmd_test;
      end
      S_TR_RD:   ;
      S_TR_WR: begin
        cmd.tr_write = 1'b1;
        cmd.tr_last  = sts.row_last;
      end
      S_TE_RD:   ;
      S_TE_PRI:  cmd.pri_start = 1'b1;
      S_TE_PRIW: cmd.pri_store = sts.div_done;
      S_TE_MUL:  cmd.mul = 1'b1;
      S_TE_DIV:  cmd.div_start = 1'b1;
      S_TE_DIVW: begin
        cmd.div_store  = sts.div_done;
        cmd.next_class = sts.div_done;
      end
      S_TE_CMP:  cmd.cmp = 1'b1;
      S_OUT:     cmd.result = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end
endmodule

// ===== rtl/cnb_dp.sv =====
module cnb_dp
  import cnb_pkg::*;
#(
  parameter int NUM_ATTRS   = NUM_ATTRS_D,
  parameter int NUM_VALUES  = NUM_VALUES_D,
  parameter int NUM_CLASSES = NUM_CLASSES_D,
  parameter int COUNT_WIDTH = COUNT_WIDTH_D
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cnb_cmd_t         cmd,
  output cnb_sts_t         sts,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [POS_W-1:0] in_pos,
  input  logic [VAL_W-1:0] in_val,
  input  logic [LBL_W-1:0] in_lbl,
  input  logic             in_last,
  input  logic [CIU_W-1:0] ciu,
  output logic [LBL_W-1:0] pred,
  output logic             found,
  output logic             correct,
  output logic [TOTAL_W-1:0] tested,
  output logic [TOTAL_W-1:0] corr_rows
);
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH  = NUM_ATTRS * NUM_VALUES * NUM_CLASSES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = COUNT_WIDTH;
  localparam logic [CW-1:0] CMAX = '1;

  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [LBL_W-1:0] lbl_r;
  logic             last_r;
  logic [ADDR_W:0]  clr_r;
  logic [CW-1:0]    cc_r [NUM_CLASSES];
  logic [CW-1:0]    rows_r;
  logic [SCORE_W-1:0] sc_r [NUM_CLASSES];
  logic [CLS_W-1:0] ci_r;
  logic [SCORE_W+CW-1:0] prod_r;
  logic [TOTAL_W-1:0] tot_r, cor_r;
  logic [LBL_W-1:0] pred_nxt;
  logic             found_nxt, corr_nxt;

  logic             elem_ok, we;
  logic [ADDR_W-1:0] raddr, waddr, base;
  logic [CW-1:0]    rdata, wdata;
  logic [CLS_W-1:0] lbl_c;
  logic             div_start, div_done;
  logic [DIV_W-1:0] dividend, quot;
  logic [31:0]      divisor;
  logic [SCORE_W-1:0] qsat;
  logic [CW-1:0]    cc_cur;

  assign elem_ok = (32'(pos_r) < NUM_ATTRS) && (32'(val_r) < NUM_VALUES);
  assign base    = ADDR_W'((32'(pos_r) * NUM_VALUES + 32'(val_r)) * NUM_CLASSES);
  assign lbl_c   = CLS_W'(lbl_r);
  assign cc_cur  = cc_r[ci_r];

  always_comb begin
    raddr = (cmd_r == CMD_TRAIN) ? base + ADDR_W'(lbl_c) : base + ADDR_W'(ci_r);
    we    = 1'b0;
    waddr = base + ADDR_W'(lbl_c);
    wdata = (rdata == CMAX) ? CMAX : rdata + CW'(1);
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_r[ADDR_W-1:0];
      wdata = '0;
    end else if (cmd.tr_write && elem_ok) begin
      we = 1'b1;
    end
  end

  cnb_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  always_comb begin
    if (cmd.pri_start) begin
      dividend = {32'(cc_cur), 32'd0};
      divisor  = 32'(rows_r);
    end else begin
      dividend = 64'(prod_r);
      divisor  = 32'(cc_cur);
    end
  end
  assign div_start = cmd.pri_start || cmd.div_start;

  cnb_div u_div (
    .clk, .rst_n, .start(div_start), .dividend, .divisor,
    .done(div_done), .quot
  );

  assign qsat = (quot[DIV_W-1:SCORE_W] != '0) ? '1 : quot[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      rows_r <= '0;
      tot_r <= '0;
      cor_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cc_r[i] <= '0;
        sc_r[i] <= '0;
      end
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + (ADDR_W+1)'(1);
      if (cmd.wipe_small) begin
        clr_r <= '0;
        rows_r <= '0;
        tot_r <= '0;
        cor_r <= '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
          cc_r[i] <= '0;
          sc_r[i] <= '0;
        end
      end
      if (cmd.tr_last) begin
        if (cc_r[lbl_c] != CMAX) cc_r[lbl_c] <= cc_r[lbl_c] + CW'(1);
        if (rows_r != CMAX) rows_r <= rows_r + CW'(1);
      end
      if (cmd.pri_store) sc_r[ci_r] <= (rows_r == '0) ? '0 : qsat;
      if (cmd.div_store) sc_r[ci_r] <= (cc_cur == '0 || !elem_ok) ? '0 : qsat;
      if (cmd.cmp) begin
        if (tot_r != '1) tot_r <= tot_r + TOTAL_W'(1);
        if (corr_nxt && cor_r != '1) cor_r <= cor_r + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      pos_r  <= in_pos;
      val_r  <= in_val;
      lbl_r  <= in_lbl;
      last_r <= in_last;
    end
    if (cmd.te_start) ci_r <= '0;
    else if (cmd.next_class) ci_r <= ci_r + CLS_W'(1);
    if (cmd.mul) prod_r <= sc_r[ci_r] * rdata;
  end

  // compare scores over the classes in use
  always_comb begin
    logic [SCORE_W-1:0] best;
    logic [3:0] n;
    best = '0;
    pred_nxt = '0;
    found_nxt = 1'b0;
    n = (ciu == '0) ? 4'd1 : 4'(ciu);
    if (32'(n) > NUM_CLASSES) n = 4'(NUM_CLASSES);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (c < 32'(n) && sc_r[c] > best) begin
        best = sc_r[c];
        pred_nxt = LBL_W'(c);
        found_nxt = 1'b1;
      end
    end
    corr_nxt = found_nxt && (pred_nxt == lbl_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      pred    <= pred_nxt;
      found   <= found_nxt;
      correct <= corr_nxt;
    end
  end

  assign tested    = tot_r;
  assign corr_rows = cor_r;

  assign sts.clr_done   = (clr_r == (ADDR_W+1)'(DEPTH - 1));
  assign sts.div_done   = div_done;
  assign sts.last_class = (32'(ci_r) == NUM_CLASSES - 1);
  assign sts.cmd_clear  = (in_cmd == CMD_CLEAR);
  assign sts.cmd_train  = (in_cmd == CMD_TRAIN);
  assign sts.cmd_test   = (in_cmd == CMD_TEST);
  assign sts.lbl_ok     = (32'(in_lbl) < NUM_CLASSES);
  assign sts.pos_zero   = (pos_r == '0);
  assign sts.row_last   = last_r;
endmodule

// ===== rtl/categorical_naive_bayes.sv =====
// channel  | dir | ports                     | tdata fields (lsb up)
// in       | in  | in_tvalid/tready/tdata    | cmd, attr_pos, attr_value, class_label
//          |     | in_tlast                  | row_last
// out      | out | out_tvalid/tready/tdata   | best_class, prediction_found,
//          |     |                           | prediction_correct, tested_rows, correct_rows
// cfg      | in  | cfg_we/cfg_wdata          | classes_in_use
// train element: read then write; test element, per class: read, a division for the prior
// on a row's first element only, multiply, then start and wait on the shared 64-step divider;
// a row's last element adds a compare and the result output
// a clear command, and reset, run a clearing pass over all NUM_ATTRS*NUM_VALUES*NUM_CLASSES
// counter entries (1024 by default), during which in_tready is low
// a held result stalls input until out_tready takes it
module categorical_naive_bayes
  import cnb_pkg::*;
#(
  parameter int NUM_ATTRS   = NUM_ATTRS_D,
  parameter int NUM_VALUES  = NUM_VALUES_D,
  parameter int NUM_CLASSES = NUM_CLASSES_D,
  parameter int COUNT_WIDTH = COUNT_WIDTH_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd, attr_pos, attr_value, class_label
  input  logic        in_tlast,   // row_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // best_class, found, correct, tested, correct_rows
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata   // classes_in_use
);
  cnb_cmd_t cmd;
  cnb_sts_t sts;
  logic in_fire;
  logic [CIU_W-1:0] ciu_r;
  logic [LBL_W-1:0] pred;
  logic found, correct;
  logic [TOTAL_W-1:0] tested, corr_rows;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n)      ciu_r <= 3'd2;
    else if (cfg_we) ciu_r <= cfg_wdata;
  end

  cnb_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free(out_tready), .sts, .cmd, .in_rdy(in_tready)
  );

  cnb_dp #(
    .NUM_ATTRS(NUM_ATTRS), .NUM_VALUES(NUM_VALUES),
    .NUM_CLASSES(NUM_CLASSES), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_cmd(in_tdata[1:0]), .in_pos(in_tdata[5:2]), .in_val(in_tdata[9:6]),
    .in_lbl(in_tdata[11:10]), .in_last(in_tlast), .ciu(ciu_r),
    .pred, .found, .correct, .tested, .corr_rows
  );

  assign out_tvalid = cmd.result;
  assign out_tdata  = {4'd0, corr_rows, tested, correct, found, pred};
endmodule

// ===== verif/categorical_naive_bayes_tb.sv =====
`timescale 1ns / 1ps

module categorical_naive_bayes_tb;
  import cnb_pkg::*;

  localparam int NA = NUM_ATTRS_D;
  localparam int NV = NUM_VALUES_D;
  localparam int NC = NUM_CLASSES_D;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam longint LIMIT = 64'd8_000_000;

  typedef struct packed {
    logic [15:0] correct_rows;
    logic [15:0] tested_rows;
    logic        correct;
    logic        found;
    logic [1:0]  pred;
  } verdict_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_wdata = '0;

  categorical_naive_bayes dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [15:0] vc_count [NA*NV*NC];
  logic [15:0] cls_count [NC];
  logic [15:0] rows_trained;
  logic [31:0] score [NC];
  logic [15:0] tot_tested, tot_correct;
  logic [2:0]  ciu;

  verdict_t verdicts_due[$];
  int errors = 0;
  bit idle_in = 1, idle_out = 1;
  int hold_cycles = 0;
  int gap_left = 0;
  longint cyc = 0;

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic wipe_counts();
    foreach (vc_count[i]) vc_count[i] = '0;
    foreach (cls_count[i]) cls_count[i] = '0;
    foreach (score[i]) score[i] = '0;
    rows_trained = '0;
    tot_tested = '0;
    tot_correct = '0;
  endtask

  task automatic classify(cmd_t cmd, logic [3:0] pos, logic [3:0] val, logic [1:0] lbl,
                          logic last);
    int idx, n;
    logic [31:0] best;
    logic [1:0] pred;
    logic found;
    verdict_t v;
    idx = (pos * NV + val) * NC;
    if (cmd == CMD_CLEAR) begin
      wipe_counts();
    end else if (cmd == CMD_TRAIN) begin
      vc_count[idx + lbl] = inc16(vc_count[idx + lbl]);
      if (last) begin
        cls_count[lbl] = inc16(cls_count[lbl]);
        rows_trained = inc16(rows_trained);
      end
    end else if (cmd == CMD_TEST) begin
      for (int c = 0; c < NC; c++) begin
        if (pos == 0)
          score[c] = (rows_trained == 0) ? 32'd0 :
                     clip32(({32'd0, 16'd0, cls_count[c]} << 32) / rows_trained);
        if (cls_count[c] == 0) score[c] = '0;
        else score[c] = clip32((64'(score[c]) * vc_count[idx + c]) / cls_count[c]);
      end
      if (last) begin
        n = (ciu == 0) ? 1 : (ciu > NC) ? NC : ciu;
        best = '0; pred = '0; found = 0;
        for (int c = 0; c < n; c++)
          if (score[c] > best) begin
            best = score[c]; pred = 2'(c); found = 1;
          end
        tot_tested = inc16(tot_tested);
        if (found && pred == lbl) tot_correct = inc16(tot_correct);
        v.pred = pred; v.found = found; v.correct = found && pred == lbl;
        v.tested_rows = tot_tested; v.correct_rows = tot_correct;
        verdicts_due.insert(verdicts_due.size(), v);
      end
    end
  endtask

  task automatic send(cmd_t cmd, logic [3:0] pos, logic [3:0] val, logic [1:0] lbl,
                      logic last);
    if (!idle_in && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'd0, lbl, val, pos, cmd};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    classify(cmd, pos, val, lbl, last);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (verdicts_due.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_classes(logic [2:0] n);
    drain();
    cfg_we <= 1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
    ciu = n;
  endtask

  task automatic train_row(int len, logic [1:0] lbl, logic [3:0] bias);
    for (int p = 0; p < len; p++)
      send(CMD_TRAIN, 4'(p), ($urandom_range(0, 2) == 0) ? 4'($urandom) : bias ^ 4'(p & 3),
           lbl, p == len - 1);
  endtask

  task automatic test_row(int len, logic [1:0] lbl, logic [3:0] bias);
    for (int p = 0; p < len; p++)
      send(CMD_TEST, 4'(p), ($urandom_range(0, 3) == 0) ? 4'($urandom) : bias ^ 4'(p & 3),
           lbl, p == len - 1);
  endtask

  task automatic test_directed();
    send(CMD_TEST, 0, 0, 0, 1);
    send(CMD_TRAIN, 0, 4'hF, 2'd3, 0);
    send(CMD_TRAIN, 4'hF, 4'hF, 2'd3, 1);
    send(CMD_TRAIN, 0, 0, 2'd0, 0);
    send(CMD_TRAIN, 4'hF, 0, 2'd0, 1);
    send(CMD_TRAIN, 0, 4'hA, 2'd1, 1);
    send(CMD_NONE, 4'hF, 4'hF, 2'd3, 1);
    send(CMD_TEST, 0, 0, 2'd0, 0);
    send(CMD_TEST, 4'hF, 0, 2'd0, 1);
    send(CMD_TEST, 0, 4'hF, 2'd3, 0);
    send(CMD_TEST, 4'hF, 4'hF, 2'd3, 1);
    send(CMD_TEST, 4'h5, 4'h5, 2'd1, 1);
    send(CMD_TEST, 0, 4'hA, 2'd1, 1);
    send(CMD_TEST, 0, 4'h3, 2'd2, 1);
    send(CMD_CLEAR, 0, 0, 0, 0);
    send(CMD_TEST, 0, 4'hA, 2'd1, 1);
  endtask

  task automatic test_class_register();
    logic [2:0] settings [6] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd3, 3'd2};
    foreach (settings[s]) begin
      set_classes(settings[s]);
      send(CMD_CLEAR, 0, 0, 0, 0);
      for (int r = 0; r < 8; r++) train_row(3, 2'(r), 4'(r));
      for (int r = 0; r < 4; r++) test_row(3, 2'(r), 4'(r));
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 3000;
    for (int r = 0; r < 6; r++) test_row(1, 2'(r), 4'(r));
  endtask

  task automatic test_random(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      int len, k;
      logic [1:0] lbl;
      logic [3:0] bias;
      k = $urandom_range(0, 99);
      lbl = 2'($urandom);
      bias = 4'($urandom);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
      if (k < 1) begin
        send(CMD_CLEAR, 4'($urandom), 4'($urandom), 2'($urandom), 1'($urandom));
        sent++;
      end else if (k < 55) begin
        train_row(len, lbl, bias);
        sent += len;
      end else if (k < 90) begin
        test_row(len, lbl, bias);
        sent += len;
      end else begin
        send(cmd_t'($urandom_range(1, 3)), 4'($urandom), 4'($urandom), 2'($urandom),
             1'($urandom));
        sent++;
      end
      if (sent > items - 150) begin
        idle_in = 1; idle_out = 1;
      end
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_cycles > 0) begin
      out_tready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else if (gap_left > 0) begin
      out_tready <= 0;
      gap_left <= gap_left - 1;
    end else if (!idle_out && $urandom_range(0, 5) == 0) begin
      out_tready <= 0;
      gap_left <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[35:0];
      if (verdicts_due.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.pred !== want.pred)
          $display("%0t pred: expected %0d actual %0d", $time, want.pred, got.pred);
        if (got.found !== want.found)
          $display("%0t found: expected %0d actual %0d", $time, want.found, got.found);
        if (got.correct !== want.correct)
          $display("%0t correct: expected %0d actual %0d", $time, want.correct, got.correct);
        if (got.tested_rows !== want.tested_rows)
          $display("%0t tested_rows: expected %0d actual %0d", $time, want.tested_rows,
                   got.tested_rows);
        if (got.correct_rows !== want.correct_rows)
          $display("%0t correct_rows: expected %0d actual %0d", $time, want.correct_rows,
                   got.correct_rows);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    wipe_counts();
    ciu = 3'd2;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    idle_in = 0; idle_out = 0;
    test_class_register();
    test_backpressure();
    test_random(1520);
    drain();
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cnb_pkg.sv
rtl/cnb_ram.sv
rtl/cnb_div.sv
rtl/cnb_ctrl.sv
rtl/cnb_dp.sv
rtl/categorical_naive_bayes.sv
verif/categorical_naive_bayes_tb.sv
